FILE: sv/binary_trie_longest_prefix_match_assert.svh
// Assertion macros for the binary trie longest-prefix-match block.
// Used by the port checker; expects signals clk and rst in scope.
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// Check a property while out of reset.
`define BTLPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define BTLPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/btlpm_pkg.sv
// Shared types and codes for the binary trie longest-prefix-match block.
// No dependencies.
`default_nettype none
package btlpm_pkg;

  // Width of the bit_count field
  localparam int BIT_COUNT_W = 6;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Contents of one cell of the address bit chain
  typedef struct packed {
    logic live;
    logic addr_bit;
  } cell_t;

  // Control for every cell of the chain
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: sv/binary_trie_longest_prefix_match.sv
// Binary trie longest-prefix-match engine. One item at a time: an item is taken
// while idle, then walks one trie level per cycle until its result shows, the
// final step waiting for a free result slot; a lookup that runs off the trie
// ends early. The pace is set by the node RAM, read once per level, while a
// chain of bit cells feeds the path bits in order.
// Node 0 (the root) lives in flops; other nodes are written when allocated.
// Depends on btlpm_pkg, btlpm_ram, btlpm_bit_cell.
`default_nettype none
module binary_trie_longest_prefix_match
  import btlpm_pkg::*;
#(
  parameter int NODE_COUNT   = 1024,
  parameter int ADDR_WIDTH   = 32,
  parameter int ROUTER_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    req_type,
  input  wire logic [ADDR_WIDTH-1:0]   addr_bits,
  input  wire logic [BIT_COUNT_W-1:0]  bit_count,
  input  wire logic [ROUTER_WIDTH-1:0] router_id,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         found,
  output logic [ROUTER_WIDTH-1:0]      router_out,
  output logic                         status
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int NODE_W = 2 * IDX_W + 1 + ROUTER_WIDTH;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                    state;
  logic                    is_lookup;
  logic [ROUTER_WIDTH-1:0] router_hold;
  logic [IDX_W-1:0]        cur;
  logic [NODE_W-1:0]       node_reg;
  logic                    use_ram;
  logic                    hit;
  logic [ROUTER_WIDTH-1:0] best;
  logic [CNT_W-1:0]        used;
  logic [NODE_W-1:0]       root_node;

  logic [NODE_W-1:0]       ram_rdata;
  logic [NODE_W-1:0]       cur_node;
  logic [IDX_W-1:0]        child0, child1, nxt, new_idx;
  logic                    lab_valid;
  logic [ROUTER_WIDTH-1:0] lab_router;
  logic                    more, path_bit, nxt_none, full;
  logic                    eff_hit;
  logic [ROUTER_WIDTH-1:0] eff_best;
  logic                    finishing, slot_free, go, accept;
  logic [NODE_W-1:0]       wb_node;
  logic                    wr, ram_we, ram_re;

  cell_ctl_t               ctl;
  cell_t                   cells [ADDR_WIDTH];

  // Address bit chain, head cell is the bit of the current level
  for (genvar i = 0; i < ADDR_WIDTH; i++) begin : g_cell
    cell_t load_val;
    cell_t shift_in;
    assign load_val.addr_bit = addr_bits[ADDR_WIDTH-1-i];
    assign load_val.live     = (bit_count > BIT_COUNT_W'(i));
    if (i == ADDR_WIDTH - 1) begin : g_last
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = cells[i+1];
    end
    btlpm_bit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .load_val (load_val),
      .shift_in (shift_in),
      .bit_q    (cells[i])
    );
  end

  // Decode the node at the current level
  assign cur_node   = use_ram ? ram_rdata : node_reg;
  assign child0     = cur_node[IDX_W-1:0];
  assign child1     = cur_node[2*IDX_W-1:IDX_W];
  assign lab_router = cur_node[2*IDX_W +: ROUTER_WIDTH];
  assign lab_valid  = cur_node[NODE_W-1];

  assign more     = cells[0].live;
  assign path_bit = cells[0].addr_bit;
  assign nxt      = path_bit ? child1 : child0;
  assign nxt_none = (nxt == '0);
  assign full     = (used == CNT_W'(NODE_COUNT));
  assign new_idx  = used[IDX_W-1:0];
  assign eff_hit  = hit | lab_valid;
  assign eff_best = lab_valid ? lab_router : best;

  assign finishing = is_lookup ? (!more || nxt_none) : (!more || (nxt_none && full));
  assign slot_free = !out_valid || !out_stall;
  assign go        = (state == ST_WALK) && (!finishing || slot_free);
  assign accept    = (state == ST_IDLE) && in_valid;
  assign in_stall  = (state != ST_IDLE);

  // Node written back on leaving it during an insert
  always_comb begin
    wb_node = cur_node;
    if (!more) begin
      wb_node[NODE_W-1]                  = 1'b1;
      wb_node[2*IDX_W +: ROUTER_WIDTH]   = router_hold;
    end else if (nxt_none && !full) begin
      if (path_bit) begin
        wb_node[2*IDX_W-1:IDX_W] = new_idx;
      end else begin
        wb_node[IDX_W-1:0] = new_idx;
      end
    end
  end

  assign wr        = go && !is_lookup;
  assign ram_we    = wr && (cur != '0);
  assign ram_re    = go && !finishing && !nxt_none;
  assign ctl.load  = accept;
  assign ctl.shift = go && !finishing;

  btlpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur),
    .wdata (wb_node),
    .re    (ram_re),
    .raddr (nxt),
    .rdata (ram_rdata)
  );

  // Control: walk state, allocation count, root node, result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= CNT_W'(1);
      root_node <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        state <= ST_WALK;
      end
      if (wr && (cur == '0)) begin
        root_node <= wb_node;
      end
      if (go) begin
        if (finishing) begin
          state     <= ST_IDLE;
          out_valid <= 1'b1;
        end else if (!is_lookup && nxt_none) begin
          used <= used + CNT_W'(1);
        end
      end
    end
  end

  // Walk payload and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      is_lookup   <= (req_type == REQ_LOOKUP);
      router_hold <= router_id;
      cur         <= '0;
      node_reg    <= root_node;
      use_ram     <= 1'b0;
      hit         <= 1'b0;
      best        <= '0;
    end else if (go) begin
      if (finishing) begin
        found      <= is_lookup && eff_hit;
        router_out <= (is_lookup && eff_hit) ? eff_best : '0;
        status     <= (!is_lookup && more) ? STATUS_FULL : STATUS_OK;
      end else begin
        hit  <= eff_hit;
        best <= eff_best;
        if (nxt_none) begin
          cur      <= new_idx;
          node_reg <= '0;
          use_ram  <= 1'b0;
        end else begin
          cur     <= nxt;
          use_ram <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/btlpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module btlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/btlpm_bit_cell.sv
// One cell of the address bit chain: holds one path bit and its live flag.
// Depends on btlpm_pkg.
`default_nettype none
module btlpm_bit_cell
  import btlpm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire cell_t     load_val,
  input  wire cell_t     shift_in,
  output cell_t          bit_q
);

  // Load a new item, or take the neighbor's bit on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_q <= '0;
    end else if (ctl.load) begin
      bit_q <= load_val;
    end else if (ctl.shift) begin
      bit_q <= shift_in;
    end
  end

endmodule
`default_nettype wire

FILE: sv/btlpm_checker.sv
// Port checker for the binary trie longest-prefix-match block, bound to the top.
// Depends on binary_trie_longest_prefix_match_assert.svh.
`default_nettype none
`include "binary_trie_longest_prefix_match_assert.svh"
module btlpm_checker #(
  parameter int ROUTER_WIDTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    found,
  input wire logic [ROUTER_WIDTH-1:0] router_out,
  input wire logic                    status
);

  // Hold a stalled result
  `BTLPM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(router_out), "stalled result changed")
  // A match never reports a full table
  `BTLPM_ASSERT(a_found_ok, out_valid && found |-> !status, "found with full status")
  // A miss carries no router
  `BTLPM_ASSERT(a_miss_zero, out_valid && !found |-> router_out == '0, "router on miss")
  // A taken item keeps the block busy next cycle
  `BTLPM_ASSERT(a_busy, in_valid && !in_stall |=> in_stall, "input not blocked while walking")

endmodule

bind binary_trie_longest_prefix_match btlpm_checker #(
  .ROUTER_WIDTH (ROUTER_WIDTH)
) u_btlpm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .found      (found),
  .router_out (router_out),
  .status     (status)
);
`default_nettype wire
